### hdl/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define TD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define TD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/td_pkg.sv
// Types, constants and helpers for the tracking differentiator
package td_pkg;

    localparam int AccW = 88;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_MAC,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef enum logic [2:0] {
        REG_ACCEL,
        REG_FSTEP,
        REG_DT,
        REG_CYCLIC,
        REG_LOW,
        REG_HIGH,
        REG_START
    } t_reg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_UNWRAP,
        S_D,
        S_D0,
        S_FH,
        S_ERR,
        S_LIN,
        S_SQ1,
        S_SQ2,
        S_SQRT,
        S_FSEL,
        S_FMUL,
        S_FDIV,
        S_POS,
        S_RATE,
        S_WRAP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        start;
        t_op         op;
        logic [63:0] opa;
        logic [63:0] opb;
        logic [6:0]  n;
    } t_alu_req;

    typedef struct packed {
        logic            busy;
        logic [AccW-1:0] acc;
        logic [32:0]     rem;
        logic [42:0]     root;
    } t_alu_rsp;

    localparam logic [30:0] RST_ACCEL  = 31'd6553600;
    localparam logic [15:0] RST_FSTEP  = 16'd655;
    localparam logic [15:0] RST_DT     = 16'd655;
    localparam logic        RST_CYCLIC = 1'b0;
    localparam logic [31:0] RST_LOW    = 32'hFFFC_DBC1;
    localparam logic [31:0] RST_HIGH   = 32'h0003_243F;
    localparam logic [31:0] RST_START  = 32'h0000_0000;

    function automatic logic [47:0] f_sat48(input logic signed [49:0] v);
        if (v > $signed({3'b000, {47{1'b1}}})) return {1'b0, {47{1'b1}}};
        if (v < $signed({3'b111, {47{1'b0}}})) return {1'b1, {47{1'b0}}};
        return v[47:0];
    endfunction

    function automatic logic [31:0] f_sat32(input logic signed [49:0] v);
        if (v > $signed({19'd0, {31{1'b1}}})) return {1'b0, {31{1'b1}}};
        if (v < $signed({{19{1'b1}}, {31{1'b0}}})) return {1'b1, {31{1'b0}}};
        return v[31:0];
    endfunction

endpackage

### hdl/td_ifs.sv
// Channel interfaces: sample input, result output, register write
interface td_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_sample;
    modport source (output valid, output raw_sample, input ready);
    modport sink (input valid, input raw_sample, output ready);
endinterface

interface td_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] tracked_value;
    logic [31:0] tracked_rate;
    modport source (output valid, output tracked_value, output tracked_rate, input ready);
    modport sink (input valid, input tracked_value, input tracked_rate, output ready);
endinterface

interface td_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/td_alu.sv
// Shared bit-serial unit: multiply, multiply-accumulate, divide, square root
module td_alu
    import td_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    t_op             r_op, n_op;
    logic [AccW-1:0] r_a, n_a;
    logic [63:0]     r_b, n_b;
    logic [AccW-1:0] r_acc, n_acc;
    logic [45:0]     r_rem, n_rem;
    logic [42:0]     r_root, n_root;
    logic [6:0]      r_cnt, n_cnt;
    logic            r_busy, n_busy;

    logic [33:0] div_sh, div_diff;
    logic        div_ge;
    logic [45:0] sq_sh, sq_t;
    logic        sq_ge;

    always_comb begin
        div_sh   = {r_rem[32:0], r_acc[63]};
        div_diff = div_sh - {1'b0, r_b[32:0]};
        div_ge   = (div_sh >= {1'b0, r_b[32:0]});
        sq_sh    = {r_rem[43:0], r_acc[85:84]};
        sq_t     = {1'b0, r_root, 2'b01};
        sq_ge    = (sq_sh >= sq_t);

        n_op   = r_op;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;

        if (i_req.start) begin
            n_op   = i_req.op;
            n_cnt  = i_req.n;
            n_busy = 1'b1;
            unique case (i_req.op)
                OP_MUL: begin
                    n_acc = '0;
                    n_a   = {{(AccW-64){i_req.opa[63]}}, i_req.opa};
                    n_b   = i_req.opb;
                end
                OP_MAC: begin
                    n_a = {{(AccW-64){i_req.opa[63]}}, i_req.opa};
                    n_b = i_req.opb;
                end
                OP_DIV: begin
                    n_acc = {{(AccW-64){1'b0}}, i_req.opa};
                    n_b   = i_req.opb;
                    n_rem = '0;
                end
                OP_SQRT: begin
                    n_rem  = '0;
                    n_root = '0;
                end
                default: n_busy = 1'b0;
            endcase
        end else if (r_busy) begin
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
            end
            case (r_op) inside
                OP_MUL, OP_MAC: begin
                    if (r_b[0]) begin
                        n_acc = r_acc + r_a;
                    end
                    n_a = {r_a[AccW-2:0], 1'b0};
                    n_b = {1'b0, r_b[63:1]};
                end
                OP_DIV: begin
                    n_rem = {13'd0, div_ge ? div_diff[32:0] : div_sh[32:0]};
                    n_acc = {r_acc[AccW-1:64], r_acc[62:0], div_ge};
                end
                default: begin
                    n_rem  = sq_ge ? (sq_sh - sq_t) : sq_sh;
                    n_root = {r_root[41:0], sq_ge};
                    n_acc  = {r_acc[AccW-3:0], 2'b00};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_a    <= n_a;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.acc  = r_acc;
    assign o_rsp.rem  = r_rem[32:0];
    assign o_rsp.root = r_root;

endmodule

### hdl/tracking_differentiator.sv
// Tracking differentiator: top level with sequencer and state
// Channels: i_in carries one raw sample per word; o_out returns one word
// per sample with the tracked value and its rate; i_cfg writes the seven
// registers by index and is always ready. Write registers only while idle.
// Writing start_value restarts tracking from that value.
// All multiplies, divides and square roots run through one bit-serial
// unit under a sequencer; the block takes one sample at a time. Every
// sample needs five 16-step multiplies and four steps outside the unit;
// the linear law adds a 64-step divide, the square-root law a 31-step
// multiply, a 50-step multiply-accumulate and a 43-step root; the
// proportional acceleration band adds a 31-step multiply and a 64-step
// divide, the cyclic wrap another 64-step divide. The next sample is
// taken only once the result is registered and the sequencer is idle.
// Reset loads the register defaults, sets value, unwrap and previous
// sample to start_value and clears the rate; the block is ready at once.
// A stalled receiver holds the result; the block finishes the next sample
// and then waits until the pending word is taken.
module tracking_differentiator
    import td_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    td_in_if.sink     i_in,
    td_out_if.source  o_out,
    td_cfg_if.sink    i_cfg
);

    t_state r_state, n_state;
    logic   r_issued, n_issued;

    logic [30:0] r_accel, n_accel;
    logic [15:0] r_h, n_h;
    logic [15:0] r_dt, n_dt;
    logic        r_cyc, n_cyc;
    logic [31:0] r_lo, n_lo;
    logic [31:0] r_hi, n_hi;

    logic [47:0] r_x1, n_x1;
    logic [31:0] r_x2, n_x2;
    logic [47:0] r_u, n_u;
    logic [31:0] r_prev, n_prev;
    logic [31:0] r_raw, n_raw;

    logic [30:0] r_d, n_d;
    logic [30:0] r_d0, n_d0;
    logic [49:0] r_e, n_e;
    logic [49:0] r_a, n_a;
    logic [31:0] r_f, n_f;

    logic        r_out_valid, n_out_valid;
    logic [31:0] r_val, n_val;
    logic [31:0] r_oval, n_oval;
    logic [31:0] r_orate, n_orate;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    logic signed [32:0] cycle, delta;
    logic signed [33:0] dbl, cyc34, step;
    logic signed [49:0] usum, e_calc, pos_sum, rate_sum, diff;
    logic [49:0] ae, absa, absdiff;
    logic [31:0] prod16;
    logic [47:0] q_lin;
    logic [42:0] half;
    logic [32:0] m;
    logic        e_neg, a_pos, op_done;

    td_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .o_rsp  (alu_rsp)
    );

    always_comb begin
        cycle   = $signed({r_hi[31], r_hi}) - $signed({r_lo[31], r_lo});
        delta   = $signed({r_raw[31], r_raw}) - $signed({r_prev[31], r_prev});
        dbl     = {delta, 1'b0};
        cyc34   = {cycle[32], cycle};
        if (dbl > cyc34) begin
            step = {delta[32], delta} - cyc34;
        end else if (dbl < -cyc34) begin
            step = {delta[32], delta} + cyc34;
        end else begin
            step = {delta[32], delta};
        end
        usum    = $signed({{2{r_u[47]}}, r_u}) + $signed({{16{step[33]}}, step});
        prod16  = alu_rsp.acc[47:16];
        e_calc  = $signed({{2{r_x1[47]}}, r_x1}) - $signed({{2{r_u[47]}}, r_u})
                + $signed({{18{prod16[31]}}, prod16});
        pos_sum = $signed({{2{r_x1[47]}}, r_x1}) + $signed({{18{prod16[31]}}, prod16});
        rate_sum = $signed({{18{r_x2[31]}}, r_x2}) + $signed({{18{prod16[31]}}, prod16});
        e_neg   = r_e[49];
        ae      = e_neg ? (50'd0 - r_e) : r_e;
        absa    = r_a[49] ? (50'd0 - r_a) : r_a;
        a_pos   = !r_a[49] && (r_a != 50'd0);
        q_lin   = (r_h == 16'd0) ? 48'd0 : alu_rsp.acc[47:0];
        half    = alu_rsp.root - {12'd0, r_d};
        diff    = $signed({{2{r_x1[47]}}, r_x1}) - $signed({{18{r_lo[31]}}, r_lo});
        absdiff = diff[49] ? (50'd0 - diff) : diff;
        m       = (diff[49] && (alu_rsp.rem != 33'd0)) ? (cycle - alu_rsp.rem)
                                                       : alu_rsp.rem;
    end

    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        n_accel     = r_accel;
        n_h         = r_h;
        n_dt        = r_dt;
        n_cyc       = r_cyc;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_x1        = r_x1;
        n_x2        = r_x2;
        n_u         = r_u;
        n_prev      = r_prev;
        n_raw       = r_raw;
        n_d         = r_d;
        n_d0        = r_d0;
        n_e         = r_e;
        n_a         = r_a;
        n_f         = r_f;
        n_val       = r_val;
        n_oval      = r_oval;
        n_orate     = r_orate;
        n_out_valid = r_out_valid;
        alu_req     = '{start: 1'b0, op: OP_MUL, opa: 64'd0, opb: 64'd0, n: 7'd0};
        op_done     = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (r_state != S_IDLE && r_state != S_UNWRAP && r_state != S_ERR
            && r_state != S_FSEL && r_state != S_DONE) begin
            if (!r_issued) begin
                alu_req.start = 1'b1;
                n_issued      = 1'b1;
            end else if (!alu_rsp.busy) begin
                op_done  = 1'b1;
                n_issued = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_raw   = i_in.raw_sample;
                    n_state = S_UNWRAP;
                end
            end
            S_UNWRAP: begin
                n_u     = r_cyc ? f_sat48(usum) : {{16{r_raw[31]}}, r_raw};
                n_prev  = r_raw;
                n_state = S_D;
            end
            S_D: begin
                alu_req.opa = {33'd0, r_accel};
                alu_req.opb = {48'd0, r_h};
                alu_req.n   = 7'd16;
                if (op_done) begin
                    n_d     = alu_rsp.acc[46:16];
                    n_state = S_D0;
                end
            end
            S_D0: begin
                alu_req.opa = {33'd0, r_d};
                alu_req.opb = {48'd0, r_h};
                alu_req.n   = 7'd16;
                if (op_done) begin
                    n_d0    = alu_rsp.acc[46:16];
                    n_state = S_FH;
                end
            end
            S_FH: begin
                alu_req.opa = {{32{r_x2[31]}}, r_x2};
                alu_req.opb = {48'd0, r_h};
                alu_req.n   = 7'd16;
                if (op_done) begin
                    n_e     = e_calc;
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_state = (ae <= {19'd0, r_d0}) ? S_LIN : S_SQ1;
            end
            S_LIN: begin
                alu_req.op  = OP_DIV;
                alu_req.opa = {ae[47:0], 16'd0};
                alu_req.opb = {48'd0, r_h};
                alu_req.n   = 7'd64;
                if (op_done) begin
                    n_a = {{18{r_x2[31]}}, r_x2}
                        + (e_neg ? (50'd0 - {2'd0, q_lin}) : {2'd0, q_lin});
                    n_state = S_FSEL;
                end
            end
            S_SQ1: begin
                alu_req.opa = {33'd0, r_d};
                alu_req.opb = {33'd0, r_d};
                alu_req.n   = 7'd31;
                if (op_done) begin
                    n_state = S_SQ2;
                end
            end
            S_SQ2: begin
                alu_req.op  = OP_MAC;
                alu_req.opa = {30'd0, r_accel, 3'b000};
                alu_req.opb = {14'd0, ae};
                alu_req.n   = 7'd50;
                if (op_done) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                alu_req.op = OP_SQRT;
                alu_req.n  = 7'd43;
                if (op_done) begin
                    n_a = {{18{r_x2[31]}}, r_x2}
                        + (e_neg ? (50'd0 - {8'd0, half[42:1]}) : {8'd0, half[42:1]});
                    n_state = S_FSEL;
                end
            end
            S_FSEL: begin
                if (absa <= {19'd0, r_d}) begin
                    if (r_d == 31'd0) begin
                        n_f     = 32'd0;
                        n_state = S_POS;
                    end else begin
                        n_state = S_FMUL;
                    end
                end else begin
                    n_f     = a_pos ? (32'd0 - {1'b0, r_accel}) : {1'b0, r_accel};
                    n_state = S_POS;
                end
            end
            S_FMUL: begin
                alu_req.opa = {33'd0, r_accel};
                alu_req.opb = {33'd0, absa[30:0]};
                alu_req.n   = 7'd31;
                if (op_done) begin
                    n_state = S_FDIV;
                end
            end
            S_FDIV: begin
                alu_req.op  = OP_DIV;
                alu_req.opa = alu_rsp.acc[63:0];
                alu_req.opb = {33'd0, r_d};
                alu_req.n   = 7'd64;
                if (op_done) begin
                    n_f     = a_pos ? (32'd0 - alu_rsp.acc[31:0]) : alu_rsp.acc[31:0];
                    n_state = S_POS;
                end
            end
            S_POS: begin
                alu_req.opa = {{32{r_x2[31]}}, r_x2};
                alu_req.opb = {48'd0, r_dt};
                alu_req.n   = 7'd16;
                if (op_done) begin
                    n_x1    = f_sat48(pos_sum);
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                alu_req.opa = {{32{r_f[31]}}, r_f};
                alu_req.opb = {48'd0, r_dt};
                alu_req.n   = 7'd16;
                if (op_done) begin
                    n_x2 = f_sat32(rate_sum);
                    if (r_cyc && (cycle > 33'sd0)) begin
                        n_state = S_WRAP;
                    end else begin
                        n_val   = f_sat32({{2{r_x1[47]}}, r_x1});
                        n_state = S_DONE;
                    end
                end
            end
            S_WRAP: begin
                alu_req.op  = OP_DIV;
                alu_req.opa = {14'd0, absdiff};
                alu_req.opb = {31'd0, cycle};
                alu_req.n   = 7'd64;
                if (op_done) begin
                    n_val   = r_lo + m[31:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_oval      = r_val;
                    n_orate     = r_x2;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ACCEL:  n_accel = i_cfg.data[30:0];
                REG_FSTEP:  n_h     = i_cfg.data[15:0];
                REG_DT:     n_dt    = i_cfg.data[15:0];
                REG_CYCLIC: n_cyc   = i_cfg.data[0];
                REG_LOW:    n_lo    = i_cfg.data;
                REG_HIGH:   n_hi    = i_cfg.data;
                REG_START: begin
                    n_x1   = {{16{i_cfg.data[31]}}, i_cfg.data};
                    n_u    = {{16{i_cfg.data[31]}}, i_cfg.data};
                    n_prev = i_cfg.data;
                    n_x2   = 32'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_accel     <= RST_ACCEL;
            r_h         <= RST_FSTEP;
            r_dt        <= RST_DT;
            r_cyc       <= RST_CYCLIC;
            r_lo        <= RST_LOW;
            r_hi        <= RST_HIGH;
            r_x1        <= {{16{RST_START[31]}}, RST_START};
            r_u         <= {{16{RST_START[31]}}, RST_START};
            r_prev      <= RST_START;
            r_x2        <= 32'd0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            r_accel     <= n_accel;
            r_h         <= n_h;
            r_dt        <= n_dt;
            r_cyc       <= n_cyc;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_x1        <= n_x1;
            r_u         <= n_u;
            r_prev      <= n_prev;
            r_x2        <= n_x2;
        end
        r_raw   <= n_raw;
        r_d     <= n_d;
        r_d0    <= n_d0;
        r_e     <= n_e;
        r_a     <= n_a;
        r_f     <= n_f;
        r_val   <= n_val;
        r_oval  <= n_oval;
        r_orate <= n_orate;
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.tracked_value = r_oval;
    assign o_out.tracked_rate  = r_orate;

endmodule

### hdl/td_checker.sv
// Port-level checks for the tracking differentiator, bound to the top level
`include "assert_macros.svh"

module td_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic [31:0] i_out_rate
);

    `TD_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value) && $stable(i_out_rate), "result word changed while stalled")
    `TD_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "sample accepted while busy")
    `TD_ASSERT(a_no_instant_result, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !$rose(i_out_valid), "result appeared right after accept")
    `TD_ASSERT_ALWAYS(a_ready_after_reset, i_clk, !i_rst_n |=> i_in_ready && !i_out_valid, "not idle after reset")

endmodule

bind tracking_differentiator td_checker u_td_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_value(o_out.tracked_value),
    .i_out_rate (o_out.tracked_rate)
);

### tb/tb_td_ifs.sv
// Testbench constants: settling wait after the last result of a phase
package tb_td_consts;
    localparam int LatencyCycles = 400;
endpackage

### tb/tb_tracking_differentiator.sv
// Self-checking testbench for the tracking differentiator: random samples, several register sets
module tb_tracking_differentiator;
    import td_pkg::*;
    import tb_td_consts::*;

    logic i_clk;
    logic i_rst_n;

    td_in_if  in_ch ();
    td_out_if out_ch ();
    td_cfg_if cfg_ch ();

    tracking_differentiator DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    typedef struct {
        logic [31:0] tvalue;
        logic [31:0] trate;
    } t_result;

    localparam longint Max48 = 64'sh7FFF_FFFF_FFFF;
    localparam longint Min48 = -Max48 - 1;
    localparam longint Max32 = 64'sh7FFF_FFFF;
    localparam longint Min32 = -Max32 - 1;

    localparam logic [31:0] Corners [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                             32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001};

    // model state
    longint m_accel, m_fstep, m_dt, m_cyclic, m_low, m_high, m_start;
    longint m_pos, m_rate, m_unwrap, m_prev;

    logic [31:0] sample_q [$];
    t_result     expected_q [$];
    int          errors;
    longint      cycles;
    logic        calm;
    int          in_gap, out_gap;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    always @(posedge i_clk) begin
        if (cycles > 64'd3000000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint fmulq(longint v, longint frac);
        longint p;
        p = v * frac;
        return p >= 0 ? p / 65536 : -((-p + 65535) / 65536);
    endfunction

    function automatic longint isqrt(logic [127:0] rad);
        logic [127:0] y;
        logic [127:0] c;
        y = 0;
        for (int b = 42; b >= 0; b--) begin
            c = y | (128'd1 << b);
            if (c * c <= rad) y = c;
        end
        return longint'(y);
    endfunction

    task automatic load_start_state();
        m_pos = m_start;
        m_unwrap = m_start;
        m_prev = m_start;
        m_rate = 0;
    endtask

    task automatic model_write(t_reg idx, logic [31:0] v);
        case (idx)
            REG_ACCEL:  m_accel = v[30:0];
            REG_FSTEP:  m_fstep = v[15:0];
            REG_DT:     m_dt = v[15:0];
            REG_CYCLIC: m_cyclic = v[0];
            REG_LOW:    m_low = longint'($signed(v));
            REG_HIGH:   m_high = longint'($signed(v));
            REG_START: begin
                m_start = longint'($signed(v));
                load_start_state();
            end
            default: ;
        endcase
    endtask

    function automatic t_result track_sample(logic [31:0] s);
        longint raw, cyc, r, h, d, d0, e, ae, a, f, x1, x2, val, delta, stp, a0, half, m;
        logic [127:0] rad;
        t_result res;
        raw = longint'($signed(s));
        cyc = m_high - m_low;
        r = m_accel;
        h = m_fstep;
        if (m_cyclic != 0) begin
            delta = raw - m_prev;
            if (2 * delta > cyc) stp = delta - cyc;
            else if (2 * delta < -cyc) stp = delta + cyc;
            else stp = delta;
            m_unwrap = clampv(m_unwrap + stp, Min48, Max48);
        end else begin
            m_unwrap = raw;
        end
        d = (r * h) / 65536;
        d0 = (d * h) / 65536;
        x1 = m_pos;
        x2 = m_rate;
        e = x1 - m_unwrap + fmulq(x2, h);
        ae = e < 0 ? -e : e;
        if (ae <= d0) begin
            a = x2 + (h != 0 ? (e * 65536) / h : 0);
        end else begin
            rad = 128'(r) * 8 * 128'(ae) + 128'(d) * 128'(d);
            a0 = isqrt(rad);
            half = (a0 - d) / 2;
            a = e > 0 ? x2 + half : x2 - half;
        end
        if ((a < 0 ? -a : a) <= d) f = d != 0 ? -((r * a) / d) : 0;
        else f = a > 0 ? -r : r;
        m_pos = clampv(x1 + fmulq(x2, m_dt), Min48, Max48);
        m_rate = clampv(x2 + fmulq(f, m_dt), Min32, Max32);
        if (m_cyclic != 0 && cyc > 0) begin
            m = (m_pos - m_low) % cyc;
            if (m < 0) m += cyc;
            val = m_low + m;
        end else begin
            val = clampv(m_pos, Min32, Max32);
        end
        m_prev = raw;
        res.tvalue = val[31:0];
        res.trate = m_rate[31:0];
        return res;
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap <= 0;
        end else if (in_ch.valid && !in_ch.ready) begin
        end else if (in_gap > 0) begin
            in_ch.valid <= 1'b0;
            in_gap <= in_gap - 1;
        end else if (sample_q.size() > 0) begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                in_ch.valid <= 1'b0;
                in_gap <= $urandom_range(0, 4);
            end else begin
                in_ch.raw_sample <= sample_q[0];
                expected_q.push_back(track_sample(sample_q[0]));
                void'(sample_q.pop_front());
                in_ch.valid <= 1'b1;
            end
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.tvalue = out_ch.tracked_value;
                got.trate = out_ch.tracked_rate;
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected word value %h rate %h", $time,
                             got.tvalue, got.trate);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.tvalue !== want.tvalue) begin
                        $display("%0t value exp %h got %h", $time, want.tvalue, got.tvalue);
                        errors++;
                    end
                    if (got.trate !== want.trate) begin
                        $display("%0t rate exp %h got %h", $time, want.trate, got.trate);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_ch.ready <= 1'b0;
                out_gap <= out_gap - 1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                out_gap <= $urandom_range(0, 4);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(t_reg idx, logic [31:0] v);
        cfg_ch.index <= idx;
        cfg_ch.data <= v;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        model_write(idx, v);
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (LatencyCycles) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_sample(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 400000)) - 200000);
            default: return 32'($signed($urandom_range(0, 2000)) - 1000 + m_prev);
        endcase
    endfunction

    initial begin
        logic [31:0] lo;
        in_ch.valid = 1'b0;
        in_ch.raw_sample = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_ACCEL;
        cfg_ch.data = '0;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        m_accel = RST_ACCEL;
        m_fstep = RST_FSTEP;
        m_dt = RST_DT;
        m_cyclic = RST_CYCLIC;
        m_low = longint'($signed(RST_LOW));
        m_high = longint'($signed(RST_HIGH));
        m_start = longint'($signed(RST_START));
        load_start_state();
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, extremes
        for (int k = 0; k < 6; k++) sample_q.push_back(Corners[k]);
        drain();
        cfg_write(REG_FSTEP, 32'd0);
        for (int k = 0; k < 4; k++) sample_q.push_back(k[0] ? 32'h0 : 32'h0002_0000);
        drain();
        cfg_write(REG_ACCEL, 32'h7FFF_FFFF);
        cfg_write(REG_FSTEP, 32'hFFFF);
        cfg_write(REG_DT, 32'hFFFF);
        cfg_write(REG_START, 32'h7FFF_0000);
        for (int k = 0; k < 5; k++) sample_q.push_back(k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        drain();
        cfg_write(REG_CYCLIC, 32'd1);
        cfg_write(REG_LOW, 32'h0001_0000);
        cfg_write(REG_HIGH, 32'h0001_0000);
        cfg_write(REG_START, 32'h0);
        for (int k = 0; k < 4; k++) sample_q.push_back($urandom());
        drain();

        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(REG_ACCEL, ph == 0 ? 32'd1 : 32'($urandom_range(1, 32'h7FFF_FFFF)));
            cfg_write(REG_FSTEP, ph == 1 ? 32'd1 : 32'($urandom_range(1, 65535)));
            cfg_write(REG_DT, ph == 2 ? 32'd1 : 32'($urandom_range(1, 65535)));
            cfg_write(REG_CYCLIC, 32'(ph % 2));
            lo = (ph == 3) ? 32'h8000_0000 : 32'($signed($urandom_range(0, 400000)) - 400000);
            cfg_write(REG_LOW, lo);
            cfg_write(REG_HIGH, ph == 3 ? 32'h7FFF_FFFF
                      : ph == 5 ? lo - 1 : lo + $urandom_range(1000, 800000));
            cfg_write(REG_START, 32'($signed($urandom_range(0, 200000)) - 100000));
            if (ph == 7) calm = 1'b1;
            for (int k = 0; k < 100; k++) begin
                sample_q.push_back(rand_sample($urandom_range(0, 5)));
                while (sample_q.size() > 4) @(posedge i_clk);
            end
            drain();
        end

        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
